// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is asserted.
`define SAOE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("saoe assertion failed");

// Implication into the next cycle, ignored while reset is asserted.
`define SAOE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("saoe assertion failed");

// Implication into the next cycle that is also checked during reset.
`define SAOE_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("saoe assertion failed");

`endif

// ----- design/saoe_pkg.sv -----
// ----------------------------------------------------------------------------
// saoe_pkg
// Types, constants and helpers of the stack allocator offset engine.
// ----------------------------------------------------------------------------
package saoe_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int ADDRESS_BITS_DEF = 32;

    localparam int SIZE_W         = 13;
    localparam int ALIGN_W        = 4;
    localparam int LG_W           = 3;
    localparam int MAX_ALIGN_LOG2 = 7;
    localparam int PAD_W          = 9;
    localparam int PAD_STORE_W    = 8;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b1;

    localparam logic [SIZE_W-1:0] BUFFER_LENGTH_RST = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_RESIZE   = 2'd2,
        OP_FREE_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NO_SPACE      = 2'd1,
        ST_OUT_OF_BOUNDS = 2'd2,
        ST_OUT_OF_ORDER  = 2'd3
    } status_t;

    typedef struct packed {
        logic ptr_null;
        logic ge_base;
        logic off_le_buf;
        logic hdr_ok;
    } req_flags_t;

    // Alignment of two pointers, rounded down to a power of two and capped.
    function automatic logic [LG_W-1:0] default_align_log2(input int address_bits);
        int bytes;
        int lg;
        bytes = 2 * address_bits / 8;
        lg = 0;
        for (int i = 0; i < MAX_ALIGN_LOG2; i++) begin
            if ((bytes >> (lg + 1)) != 0) begin
                lg = lg + 1;
            end
        end
        return LG_W'(lg);
    endfunction

endpackage

// ----- design/stack_allocator_offset_engine_top.sv -----
// ----------------------------------------------------------------------------
// stack_allocator_offset_engine_top
// Offset engine of a stack allocator with a per-block header: allocate,
// free, resize and free-all requests on one region, one result per request.
//
//   Channel   Ports           Contents (lowest bits first)
//   request   s_t*            tuser: opcode; tdata: address, size, prev_size,
//                             alignment_log2
//   result    m_t*            tuser: status; tdata: result_address,
//                             copy_length, current_offset
//   config    cfg_*           index 0 base_address, index 1 buffer_length
//
// A request is registered on acceptance and its header padding is read from
// the padding RAM in the same cycle; the result is registered from the request
// register once the result register is free or being read. One request per
// cycle is sustained while m_tready does not stall the result. The padding RAM
// has no clearing pass; reset clears only the stack top, the configuration and
// the handshake state. A stalled result holds the request register, and one
// more request is taken only while that register is empty or is being emptied.
// ----------------------------------------------------------------------------
module stack_allocator_offset_engine_top #(
    parameter int BUFFER_BYTES = saoe_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = saoe_pkg::HEADER_BYTES_DEF,
    parameter int ADDRESS_BITS = saoe_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // address, size, prev_size, alignment_log2
    input  logic [((ADDRESS_BITS+30+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_address, copy_length, current_offset
    output logic [((ADDRESS_BITS+26+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [saoe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [saoe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import saoe_pkg::*;

    localparam int S_W   = ((ADDRESS_BITS + 30 + 7) / 8) * 8;
    localparam int M_W   = ((ADDRESS_BITS + 26 + 7) / 8) * 8;
    localparam int OFF_W = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W = $clog2(BUFFER_BYTES);

    logic                    accept;
    logic                    fire;

    logic [ADDRESS_BITS-1:0] base_reg, base_next;
    logic [SIZE_W-1:0]       blen_reg, blen_next;
    logic [OFF_W-1:0]        top_reg;

    logic                    st_valid;
    op_t                     st_op;
    logic [ADDRESS_BITS-1:0] st_ptr;
    logic [SIZE_W-1:0]       st_size;
    logic [SIZE_W-1:0]       st_prev_size;
    logic [ALIGN_W-1:0]      st_lg;
    logic [OFF_W-1:0]        st_off;
    req_flags_t              st_flags;
    logic [PAD_STORE_W-1:0]  st_pad;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [PAD_STORE_W-1:0]  ram_rdata;

    logic [OFF_W-1:0]        top_next;
    status_t                 ex_status;
    logic [ADDRESS_BITS-1:0] ex_addr;
    logic [SIZE_W-1:0]       ex_copy;
    logic                    ex_wr_en;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [PAD_STORE_W-1:0]  wr_data;

    logic                    m_valid_reg;
    logic [M_W-1:0]          m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    assign fire     = st_valid && (!m_valid_reg || m_tready);
    assign s_tready = !st_valid || fire;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = fire && ex_wr_en;

    always_comb begin
        base_next = base_reg;
        blen_next = blen_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_BASE_ADDRESS: begin
                    base_next = ADDRESS_BITS'(cfg_wdata);
                end
                CFG_BUFFER_LENGTH: begin
                    blen_next = cfg_wdata[SIZE_W-1:0];
                end
                default: begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            blen_reg    <= BUFFER_LENGTH_RST;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            base_reg <= base_next;
            blen_reg <= blen_next;
            if (fire) begin
                top_reg <= top_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tuser_reg <= ex_status;
            m_tdata_reg <= M_W'({SIZE_W'(top_next), ex_copy, ex_addr});
        end
    end

    saoe_ram #(
        .DATA_W (PAD_STORE_W),
        .DEPTH  (BUFFER_BYTES)
    ) u_pad_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    saoe_intake #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .S_W          (S_W),
        .OFF_W        (OFF_W),
        .IDX_W        (IDX_W)
    ) u_intake (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .fire      (fire),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .base      (base_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .ram_rdata (ram_rdata),
        .valid     (st_valid),
        .op        (st_op),
        .ptr       (st_ptr),
        .size      (st_size),
        .prev_size (st_prev_size),
        .lg        (st_lg),
        .off_t     (st_off),
        .flags     (st_flags),
        .pad       (st_pad),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    saoe_exec #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .OFF_W        (OFF_W),
        .IDX_W        (IDX_W)
    ) u_exec (
        .op        (st_op),
        .ptr       (st_ptr),
        .size      (st_size),
        .prev_size (st_prev_size),
        .lg        (st_lg),
        .off_t     (st_off),
        .flags     (st_flags),
        .pad_rd    (st_pad),
        .top       (top_reg),
        .base      (base_reg),
        .blen      (blen_reg),
        .top_next  (top_next),
        .status    (ex_status),
        .res_addr  (ex_addr),
        .copy_len  (ex_copy),
        .wr_en     (ex_wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/saoe_ram.sv -----
// ----------------------------------------------------------------------------
// saoe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module saoe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/saoe_intake.sv -----
// ----------------------------------------------------------------------------
// saoe_intake
// Request register: latches a request, derives its region offset and issues
// the header read of the padding memory, with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module saoe_intake #(
    parameter int BUFFER_BYTES = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int ADDRESS_BITS = 32,
    parameter int S_W          = 64,
    parameter int OFF_W        = 13,
    parameter int IDX_W        = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              fire,
    input  logic [S_W-1:0]                    s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic [ADDRESS_BITS-1:0]           base,
    input  logic                              wr_en,
    input  logic [IDX_W-1:0]                  wr_addr,
    input  logic [saoe_pkg::PAD_STORE_W-1:0]  wr_data,
    input  logic [saoe_pkg::PAD_STORE_W-1:0]  ram_rdata,
    output logic                              valid,
    output saoe_pkg::op_t                     op,
    output logic [ADDRESS_BITS-1:0]           ptr,
    output logic [saoe_pkg::SIZE_W-1:0]       size,
    output logic [saoe_pkg::SIZE_W-1:0]       prev_size,
    output logic [saoe_pkg::ALIGN_W-1:0]      lg,
    output logic [OFF_W-1:0]                  off_t,
    output saoe_pkg::req_flags_t              flags,
    output logic [saoe_pkg::PAD_STORE_W-1:0]  pad,
    output logic                              rd_en,
    output logic [IDX_W-1:0]                  rd_addr
);
    import saoe_pkg::*;

    localparam int WIDE_W = (ADDRESS_BITS > OFF_W + 1) ? ADDRESS_BITS : OFF_W + 1;

    logic [ADDRESS_BITS-1:0] in_addr;
    logic [ADDRESS_BITS-1:0] off_full;
    logic [OFF_W-1:0]        in_off;
    req_flags_t              in_flags;

    logic                    valid_reg, valid_next;
    op_t                     op_reg;
    logic [ADDRESS_BITS-1:0] ptr_reg;
    logic [SIZE_W-1:0]       size_reg;
    logic [SIZE_W-1:0]       prev_size_reg;
    logic [ALIGN_W-1:0]      lg_reg;
    logic [OFF_W-1:0]        off_reg;
    req_flags_t              flags_reg;
    logic                    byp_valid_reg;
    logic [PAD_STORE_W-1:0]  byp_data_reg;

    assign in_addr  = s_tdata[ADDRESS_BITS-1:0];
    assign off_full = in_addr - base;
    assign in_off   = OFF_W'(off_full);

    always_comb begin
        in_flags.ptr_null   = (in_addr == '0);
        in_flags.ge_base    = (in_addr >= base);
        in_flags.off_le_buf = (WIDE_W'(off_full) <= WIDE_W'(BUFFER_BYTES));
        in_flags.hdr_ok     = (in_off >= OFF_W'(HEADER_BYTES));
    end

    assign rd_en   = accept;
    assign rd_addr = IDX_W'(in_off - OFF_W'(HEADER_BYTES));

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg        <= op_t'(s_tuser);
            ptr_reg       <= in_addr;
            size_reg      <= s_tdata[ADDRESS_BITS+SIZE_W-1:ADDRESS_BITS];
            prev_size_reg <= s_tdata[ADDRESS_BITS+2*SIZE_W-1:ADDRESS_BITS+SIZE_W];
            lg_reg        <= s_tdata[ADDRESS_BITS+2*SIZE_W+ALIGN_W-1:ADDRESS_BITS+2*SIZE_W];
            off_reg       <= in_off;
            flags_reg     <= in_flags;
            byp_valid_reg <= wr_en && (wr_addr == rd_addr);
            byp_data_reg  <= wr_data;
        end
    end

    assign valid     = valid_reg;
    assign op        = op_reg;
    assign ptr       = ptr_reg;
    assign size      = size_reg;
    assign prev_size = prev_size_reg;
    assign lg        = lg_reg;
    assign off_t     = off_reg;
    assign flags     = flags_reg;
    assign pad       = byp_valid_reg ? byp_data_reg : ram_rdata;

endmodule

// ----- design/saoe_exec.sv -----
// ----------------------------------------------------------------------------
// saoe_exec
// Request evaluation: alignment padding, space and bounds checks, order
// checks of free and resize, and the next stack top for one latched request.
// ----------------------------------------------------------------------------
module saoe_exec #(
    parameter int BUFFER_BYTES = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int ADDRESS_BITS = 32,
    parameter int OFF_W        = 13,
    parameter int IDX_W        = 12
) (
    input  saoe_pkg::op_t                     op,
    input  logic [ADDRESS_BITS-1:0]           ptr,
    input  logic [saoe_pkg::SIZE_W-1:0]       size,
    input  logic [saoe_pkg::SIZE_W-1:0]       prev_size,
    input  logic [saoe_pkg::ALIGN_W-1:0]      lg,
    input  logic [OFF_W-1:0]                  off_t,
    input  saoe_pkg::req_flags_t              flags,
    input  logic [saoe_pkg::PAD_STORE_W-1:0]  pad_rd,
    input  logic [OFF_W-1:0]                  top,
    input  logic [ADDRESS_BITS-1:0]           base,
    input  logic [saoe_pkg::SIZE_W-1:0]       blen,
    output logic [OFF_W-1:0]                  top_next,
    output saoe_pkg::status_t                 status,
    output logic [ADDRESS_BITS-1:0]           res_addr,
    output logic [saoe_pkg::SIZE_W-1:0]       copy_len,
    output logic                              wr_en,
    output logic [IDX_W-1:0]                  wr_addr,
    output logic [saoe_pkg::PAD_STORE_W-1:0]  wr_data
);
    import saoe_pkg::*;

    localparam int SUM_W = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W) + 2;
    localparam logic [LG_W-1:0] DEF_LG = default_align_log2(ADDRESS_BITS);

    logic [SUM_W-1:0]          region;
    logic [LG_W-1:0]           lg_cap;
    logic [LG_W-1:0]           lg_e;
    logic [PAD_W-1:0]          align;
    logic [MAX_ALIGN_LOG2-1:0] cur_low;
    logic [PAD_W-1:0]          mod;
    logic [PAD_W-1:0]          pad0;
    logic [PAD_W-1:0]          need;
    logic [PAD_W-1:0]          pad;
    logic [SUM_W-1:0]          newoff;
    logic [SUM_W-1:0]          total;
    logic                      alloc_ok;
    logic                      alloc_wr;
    logic [ADDRESS_BITS-1:0]   alloc_addr;
    logic                      inb;
    logic [PAD_STORE_W-1:0]    pad_use;
    logic [OFF_W-1:0]          free_top;

    assign region = (SUM_W'(blen) > SUM_W'(BUFFER_BYTES)) ? SUM_W'(BUFFER_BYTES)
                                                          : SUM_W'(blen);

    assign lg_cap = (lg > ALIGN_W'(MAX_ALIGN_LOG2)) ? LG_W'(MAX_ALIGN_LOG2) : lg[LG_W-1:0];
    assign lg_e   = (op == OP_RESIZE && flags.ptr_null) ? DEF_LG : lg_cap;
    assign align  = PAD_W'(1) << lg_e;

    assign cur_low = base[MAX_ALIGN_LOG2-1:0] + top[MAX_ALIGN_LOG2-1:0];
    assign mod     = PAD_W'(cur_low) & (align - PAD_W'(1));
    assign pad0    = (mod != '0) ? align - mod : '0;
    assign need    = PAD_W'(HEADER_BYTES) - pad0;

    always_comb begin
        pad = pad0;
        if (pad0 < PAD_W'(HEADER_BYTES)) begin
            pad = pad0 + (((need + align - PAD_W'(1)) >> lg_e) << lg_e);
        end
    end

    assign newoff     = SUM_W'(top) + SUM_W'(pad);
    assign total      = newoff + SUM_W'(size);
    assign alloc_ok   = (total <= region);
    assign alloc_wr   = alloc_ok && (newoff >= SUM_W'(HEADER_BYTES));
    assign alloc_addr = base + ADDRESS_BITS'(newoff);

    assign inb      = flags.ge_base && flags.off_le_buf && (SUM_W'(off_t) <= region);
    assign pad_use  = flags.hdr_ok ? pad_rd : '0;
    assign free_top = (SUM_W'(pad_use) <= SUM_W'(off_t))
                    ? OFF_W'(SUM_W'(off_t) - SUM_W'(pad_use)) : '0;

    assign wr_addr = IDX_W'(newoff - SUM_W'(HEADER_BYTES));
    assign wr_data = pad[PAD_STORE_W-1:0];

    always_comb begin
        logic do_alloc;
        logic do_free;
        do_alloc = 1'b0;
        do_free  = 1'b0;
        status   = ST_OK;
        res_addr = '0;
        copy_len = '0;
        top_next = top;
        wr_en    = 1'b0;

        case (op)
            OP_ALLOC: begin
                do_alloc = 1'b1;
            end
            OP_FREE: begin
                do_free = 1'b1;
            end
            OP_RESIZE: begin
                if (flags.ptr_null) begin
                    do_alloc = 1'b1;
                end else if (size == '0) begin
                    do_free = 1'b1;
                end else if (prev_size == size) begin
                    res_addr = ptr;
                end else if (!inb) begin
                    status = ST_OUT_OF_BOUNDS;
                end else if (off_t > top) begin
                    status = ST_OUT_OF_ORDER;
                end else begin
                    do_alloc = 1'b1;
                    if (alloc_ok) begin
                        copy_len = (prev_size < size) ? prev_size : size;
                    end
                end
            end
            OP_FREE_ALL: begin
                top_next = '0;
            end
            default: begin
                top_next = top;
            end
        endcase

        if (do_alloc) begin
            if (alloc_ok) begin
                top_next = OFF_W'(total);
                res_addr = alloc_addr;
                wr_en    = alloc_wr;
            end else begin
                status = ST_NO_SPACE;
            end
        end

        if (do_free && !flags.ptr_null) begin
            if (!inb) begin
                status = ST_OUT_OF_BOUNDS;
            end else if (off_t >= top) begin
                status = ST_OUT_OF_ORDER;
            end else begin
                top_next = free_top;
            end
        end
    end

endmodule

// ----- design/saoe_checker.sv -----
// ----------------------------------------------------------------------------
// saoe_checker
// Port-level checks of the stack allocator offset engine, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module saoe_checker #(
    parameter int BUFFER_BYTES = saoe_pkg::BUFFER_BYTES_DEF,
    parameter int ADDRESS_BITS = saoe_pkg::ADDRESS_BITS_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((ADDRESS_BITS+26+7)/8)*8-1:0] m_tdata,
    input logic [1:0]                           m_tuser
);
    import saoe_pkg::*;

    localparam int CUR_W = (SIZE_W > $clog2(BUFFER_BYTES + 1)) ? SIZE_W
                                                               : $clog2(BUFFER_BYTES + 1);

    logic [ADDRESS_BITS-1:0] res_addr;
    logic [SIZE_W-1:0]       copy_len;
    logic [SIZE_W-1:0]       cur_off;

    assign res_addr = m_tdata[ADDRESS_BITS-1:0];
    assign copy_len = m_tdata[ADDRESS_BITS+SIZE_W-1:ADDRESS_BITS];
    assign cur_off  = m_tdata[ADDRESS_BITS+2*SIZE_W-1:ADDRESS_BITS+SIZE_W];

    `SAOE_ASSERT_NXT_ALL(a_no_result_after_reset, aclk, !aresetn, !m_tvalid)
    `SAOE_ASSERT_IMP(a_fail_null_address, aclk, aresetn,
        m_tvalid && (m_tuser != ST_OK), res_addr == '0)
    `SAOE_ASSERT_IMP(a_copy_only_on_move, aclk, aresetn,
        m_tvalid && (copy_len != '0), m_tuser == ST_OK)
    `SAOE_ASSERT_IMP(a_offset_in_region, aclk, aresetn,
        m_tvalid, CUR_W'(cur_off) <= CUR_W'(BUFFER_BYTES))
    `SAOE_ASSERT_NXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule

bind stack_allocator_offset_engine_top saoe_checker #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
) u_saoe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/stack_allocator_offset_engine_top_tb.sv -----
// ----------------------------------------------------------------------------
// stack_allocator_offset_engine_top_tb
// Self-checking bench for the stack allocator offset engine. A short list of
// directed requests covers the field extremes, every opcode and the corner
// cases of the allocator. Randomized, mostly well-formed allocate, free,
// resize and free-all traffic follows under several region settings and
// handshake pressure patterns. Each result is compared with the values of its
// directed row, else with an in-bench model of stack top and header padding.
// ----------------------------------------------------------------------------
module stack_allocator_offset_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import saoe_pkg::*;

    localparam int HDR_BYTES       = HEADER_BYTES_DEF;
    localparam int REGION_MAX      = BUFFER_BYTES_DEF;
    localparam int NULL_RESIZE_LG2 = 3;
    localparam int PHASE_COUNT     = 7;
    localparam int PHASE_REQUESTS  = 150;
    localparam int STALL_LIMIT     = 5000;

    typedef struct {
        status_t     status;
        logic [31:0] address;
        logic [12:0] copy_len;
        logic [12:0] offset;
    } alloc_result_t;

    typedef struct {
        op_t           op;
        logic [31:0]   ptr;
        logic [12:0]   size;
        logic [12:0]   prev_size;
        logic [3:0]    align_lg2;
        bit            fixed;
        alloc_result_t want;
    } req_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [31:0]  model_base;
    int unsigned  model_len;
    int unsigned  alloc_top;
    logic [7:0]   pad_mem [REGION_MAX];
    bit           pad_written [REGION_MAX];
    int unsigned  live_offs [$];

    alloc_result_t pending_results [$];
    int            mismatch_count   = 0;
    int            sender_idle_pct  = 0;
    int            recv_stall_pct   = 0;
    int            quiet_cycles     = 0;

    stack_allocator_offset_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned region_bytes();
        return (model_len > REGION_MAX) ? REGION_MAX : model_len;
    endfunction

    function automatic bit locate(input logic [31:0] ptr, output int unsigned off);
        logic [31:0] delta;
        delta = ptr - model_base;
        off = delta;
        return (ptr >= model_base) && (delta <= region_bytes());
    endfunction

    function automatic status_t try_allocate(input logic [12:0] size, input int unsigned lg2,
                                             output logic [31:0] addr);
        int unsigned lgc;
        int unsigned align;
        int unsigned misalign;
        int unsigned pad;
        int unsigned newoff;
        logic [31:0] cur;
        lgc = (lg2 > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : lg2;
        align = 1 << lgc;
        cur = model_base + 32'(alloc_top);
        misalign = cur & (align - 1);
        pad = (misalign != 0) ? align - misalign : 0;
        if (pad < HDR_BYTES) begin
            pad += ((HDR_BYTES - pad + align - 1) >> lgc) << lgc;
        end
        addr = '0;
        if (alloc_top + pad + size > region_bytes()) begin
            return ST_NO_SPACE;
        end
        newoff = alloc_top + pad;
        if (newoff >= HDR_BYTES && newoff - HDR_BYTES < REGION_MAX) begin
            pad_mem[newoff - HDR_BYTES] = pad[7:0];
            pad_written[newoff - HDR_BYTES] = 1'b1;
        end
        alloc_top = newoff + size;
        addr = model_base + 32'(newoff);
        live_offs.push_back(newoff);
        return ST_OK;
    endfunction

    function automatic status_t release_block(input logic [31:0] ptr);
        int unsigned off;
        int unsigned pad;
        pad = 0;
        if (ptr == '0) begin
            return ST_OK;
        end
        if (!locate(ptr, off)) begin
            return ST_OUT_OF_BOUNDS;
        end
        if (off >= alloc_top) begin
            return ST_OUT_OF_ORDER;
        end
        if (off >= HDR_BYTES && off - HDR_BYTES < REGION_MAX) begin
            pad = pad_mem[off - HDR_BYTES];
        end
        alloc_top = (pad <= off) ? off - pad : 0;
        return ST_OK;
    endfunction

    function automatic alloc_result_t compute_alloc_result(input req_row_t req);
        alloc_result_t r;
        int unsigned   off;
        r.status = ST_OK;
        r.address = '0;
        r.copy_len = '0;
        case (req.op)
            OP_ALLOC: begin
                r.status = try_allocate(req.size, req.align_lg2, r.address);
            end
            OP_FREE: begin
                r.status = release_block(req.ptr);
            end
            OP_RESIZE: begin
                if (req.ptr == '0) begin
                    r.status = try_allocate(req.size, NULL_RESIZE_LG2, r.address);
                end else if (req.size == '0) begin
                    r.status = release_block(req.ptr);
                end else if (req.prev_size == req.size) begin
                    r.address = req.ptr;
                end else if (!locate(req.ptr, off)) begin
                    r.status = ST_OUT_OF_BOUNDS;
                end else if (off > alloc_top) begin
                    r.status = ST_OUT_OF_ORDER;
                end else begin
                    r.status = try_allocate(req.size, req.align_lg2, r.address);
                    if (r.status == ST_OK) begin
                        r.copy_len = (req.prev_size < req.size) ? req.prev_size : req.size;
                    end
                end
            end
            default: begin
                alloc_top = 0;
            end
        endcase
        while (live_offs.size() != 0 && live_offs[$] >= alloc_top) begin
            void'(live_offs.pop_back());
        end
        r.offset = alloc_top[12:0];
        return r;
    endfunction

    // A free of a header slot that no allocation ever wrote would read
    // uninitialized padding memory in the block.
    function automatic bit reads_unwritten(input req_row_t req);
        int unsigned off;
        if (!(req.op == OP_FREE || (req.op == OP_RESIZE && req.size == '0))) begin
            return 1'b0;
        end
        if (req.ptr == '0 || !locate(req.ptr, off) || off >= alloc_top) begin
            return 1'b0;
        end
        return off >= HDR_BYTES && off - HDR_BYTES < REGION_MAX && !pad_written[off - HDR_BYTES];
    endfunction

    function automatic logic [12:0] pick_size();
        if ($urandom_range(99) < 85) begin
            return 13'($urandom_range(48));
        end
        return 13'($urandom_range(4096));
    endfunction

    function automatic logic [31:0] pick_pointer();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return $urandom;
        end else if (r < 30) begin
            return model_base + 32'($urandom_range(region_bytes() + 16));
        end else if (live_offs.size() == 0) begin
            return '0;
        end else if (r < 42) begin
            return model_base + 32'(live_offs[$urandom_range(live_offs.size() - 1)]);
        end
        return model_base + 32'(live_offs[$]);
    endfunction

    function automatic req_row_t make_random_request();
        req_row_t req;
        int       pick;
        pick = $urandom_range(99);
        req.op = OP_ALLOC;
        req.ptr = '0;
        req.size = pick_size();
        req.prev_size = pick_size();
        req.align_lg2 = 4'($urandom_range(15));
        req.fixed = 1'b0;
        req.want = '{ST_OK, '0, '0, '0};
        if (pick < 38) begin
            req.op = OP_ALLOC;
        end else if (pick < 68) begin
            req.op = OP_FREE;
            req.ptr = pick_pointer();
        end else if (pick < 93) begin
            req.op = OP_RESIZE;
            req.ptr = pick_pointer();
            pick = $urandom_range(99);
            if (pick < 15) begin
                req.size = '0;
            end else if (pick < 30) begin
                req.size = req.prev_size;
            end
        end else if (pick < 97) begin
            req.op = OP_FREE_ALL;
        end else begin
            req.op = op_t'($urandom_range(3));
            req.ptr = $urandom;
            req.size = 13'($urandom_range(4096));
            req.prev_size = 13'($urandom_range(4096));
        end
        if (reads_unwritten(req)) begin
            req.ptr = model_base + 32'(alloc_top);
        end
        return req;
    endfunction

    task automatic send_request(input req_row_t req);
        alloc_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {2'b00, req.align_lg2, req.prev_size, req.size, req.ptr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = compute_alloc_result(req);
        pending_results.push_back(req.fixed ? req.want : predicted);
    endtask

    task automatic write_region(input logic [31:0] base, input logic [12:0] len);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_ADDRESS;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_index <= CFG_BUFFER_LENGTH;
        cfg_wdata <= {19'b0, len};
        @(posedge aclk);
        cfg_we <= 1'b0;
        model_base = base;
        model_len  = len;
    endtask

    function automatic void add_row(ref req_row_t rows[$], input op_t op, input logic [31:0] ptr,
                                    input int size, input int prev_size, input int lg2,
                                    input bit fixed, input status_t st,
                                    input logic [31:0] addr, input int cp, input int top);
        req_row_t row;
        row.op = op;
        row.ptr = ptr;
        row.size = 13'(size);
        row.prev_size = 13'(prev_size);
        row.align_lg2 = 4'(lg2);
        row.fixed = fixed;
        row.want = '{st, addr, 13'(cp), 13'(top)};
        rows.push_back(row);
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d address %h", m_tuser, m_tdata[31:0]);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] != want.address) begin
                    $error("result_address: expected %h, actual %h", want.address,
                           m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[44:32] != want.copy_len) begin
                    $error("copy_length: expected %0d, actual %0d", want.copy_len,
                           m_tdata[44:32]);
                    mismatch_count++;
                end
                if (m_tdata[57:45] != want.offset) begin
                    $error("current_offset: expected %0d, actual %0d", want.offset,
                           m_tdata[57:45]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        req_row_t    directed [$];
        logic [31:0] phase_base [PHASE_COUNT];
        logic [12:0] phase_len  [PHASE_COUNT];
        int          mode;

        model_base = '0;
        model_len  = 4096;
        alloc_top  = 0;
        foreach (pad_written[i]) pad_written[i] = 1'b0;

        add_row(directed, OP_FREE,     32'd0,    0,    0,    0, 1, ST_OK,            '0,  0, 0);
        add_row(directed, OP_FREE,     32'd100,  0,    0,    0, 1, ST_OUT_OF_ORDER,  '0,  0, 0);
        add_row(directed, OP_FREE,     32'd5000, 0,    0,    0, 1, ST_OUT_OF_BOUNDS, '0,  0, 0);
        add_row(directed, OP_ALLOC,    32'd0,    4096, 0,    0, 1, ST_NO_SPACE,      '0,  0, 0);
        add_row(directed, OP_ALLOC,    32'd0,    4088, 0,    0, 1, ST_OK,            8,   0, 4096);
        add_row(directed, OP_FREE,     32'd8,    0,    0,    0, 1, ST_OK,            '0,  0, 0);
        add_row(directed, OP_ALLOC,    32'd0,    16,   0,    15, 1, ST_OK,           128, 0, 144);
        add_row(directed, OP_ALLOC,    32'd0,    5,    0,    2, 1, ST_OK,            152, 0, 157);
        add_row(directed, OP_ALLOC,    32'd0,    3,    0,    3, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_RESIZE,   32'd0,    20,   7,    9, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_RESIZE,   32'd184,  20,   20,   0, 1, ST_OK,            184, 0, 204);
        add_row(directed, OP_RESIZE,   32'd168,  40,   3,    0, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_RESIZE,   32'd300,  10,   4,    0, 1, ST_OUT_OF_ORDER,  '0,  0, 252);
        add_row(directed, OP_RESIZE,   32'd5000, 10,   4,    0, 1, ST_OUT_OF_BOUNDS, '0,  0, 252);
        add_row(directed, OP_RESIZE,   32'd212,  100,  4096, 1, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_RESIZE,   32'd212,  0,    100,  0, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_ALLOC,    32'd0,    4096, 0,    7, 1, ST_NO_SPACE,      '0,  0, 204);
        add_row(directed, OP_RESIZE,   32'd0,    4096, 0,    0, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_RESIZE,   32'd184,  4000, 10,   8, 0, ST_OK,            '0,  0, 0);
        add_row(directed, OP_FREE,     32'd204,  0,    0,    0, 1, ST_OUT_OF_ORDER,  '0,  0, 204);
        add_row(directed, OP_FREE,     32'd4,    0,    0,    0, 1, ST_OK,            '0,  0, 4);
        add_row(directed, OP_FREE_ALL, 32'd0,    0,    0,    0, 1, ST_OK,            '0,  0, 0);
        add_row(directed, OP_FREE,     32'hFFFF_FFFF, 4096, 4096, 15, 1, ST_OUT_OF_BOUNDS,
                '0, 0, 0);

        phase_base[0] = 32'h0000_1000;  phase_len[0] = 13'd4096;
        phase_base[1] = 32'hFFFF_FF00;  phase_len[1] = 13'd4096;
        phase_base[2] = 32'hFFFF_FFFF;  phase_len[2] = 13'd0;
        phase_base[3] = $urandom;       phase_len[3] = 13'($urandom_range(64, 4096));
        phase_base[4] = 32'h0000_0000;  phase_len[4] = 13'd8191;
        phase_base[5] = $urandom;       phase_len[5] = 13'd4096;
        phase_base[6] = 32'h8000_0003;  phase_len[6] = 13'd300;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_request(directed[i]);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_region(phase_base[p], phase_len[p]);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                if (i % 40 == 0) begin
                    mode = (i / 40 + p) % 4;
                    sender_idle_pct = (mode == 1) ? 74 : (mode == 3) ? 6 : 0;
                    recv_stall_pct  = (mode == 2) ? 74 : (mode == 3) ? 6 : 0;
                end
                send_request(make_random_request());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
